>>> hdl/ipdc_pkg.sv
// ----------------------------------------------------------------------------
// ipdc_pkg
// Shared types and constants for the IR pulse-distance command decoder.
// ----------------------------------------------------------------------------
package ipdc_pkg;

  localparam int unsigned GapW   = 16;
  localparam int unsigned WordW  = 32;
  localparam int unsigned LevelW = 8;
  localparam int unsigned CntW   = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [GapW-1:0]   START_THR_RST = 16'd8000;
  localparam logic [GapW-1:0]   ONE_THR_RST   = 16'd1700;
  localparam logic [GapW-1:0]   ZERO_THR_RST  = 16'd1000;
  localparam logic [WordW-1:0]  TOGGLE_RST    = 32'd16753245;
  localparam logic [WordW-1:0]  REVERSE_RST   = 32'd16736925;
  localparam logic [WordW-1:0]  UP_RST        = 32'd16718055;
  localparam logic [WordW-1:0]  DOWN_RST      = 32'd16730805;
  localparam logic [LevelW-1:0] CEILING_RST   = 8'd190;

  localparam logic [LevelW-1:0] LEVEL_STEP = 8'd10;
  localparam logic [LevelW:0]   LEVEL_MAX  = 9'd254;
  localparam logic [CntW-1:0]   LAST_BIT   = 5'd31;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_THR = 3'd0,
    REG_ONE_THR   = 3'd1,
    REG_ZERO_THR  = 3'd2,
    REG_TOGGLE    = 3'd3,
    REG_REVERSE   = 3'd4,
    REG_UP        = 3'd5,
    REG_DOWN      = 3'd6,
    REG_CEILING   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [GapW-1:0] start_thr;
    logic [GapW-1:0] one_thr;
    logic [GapW-1:0] zero_thr;
  } thr_cfg_t;

  typedef struct packed {
    logic [WordW-1:0]  toggle_code;
    logic [WordW-1:0]  reverse_code;
    logic [WordW-1:0]  up_code;
    logic [WordW-1:0]  down_code;
    logic [LevelW-1:0] duty_ceiling;
  } cmd_cfg_t;

  typedef struct packed {
    logic             done;
    logic             ok;
    logic [WordW-1:0] word;
  } frame_evt_t;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic              motor_on;
    logic              direction;
  } ctrl_state_t;

endpackage

>>> hdl/ipdc_frame_rx.sv
// ----------------------------------------------------------------------------
// ipdc_frame_rx
// Gap classification, MSB-first bit shifter and frame check.
// ----------------------------------------------------------------------------
module ipdc_frame_rx
  import ipdc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic [GapW-1:0] gap,
  input  thr_cfg_t        thr,
  output frame_evt_t      evt
);

  logic [WordW-1:0] word_r, word_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             is_start, is_one, is_zero, is_bit;
  logic [WordW-1:0] bit_mask;

  always_comb begin
    is_start = gap > thr.start_thr;
    is_one   = !is_start && (gap > thr.one_thr);
    is_zero  = !is_start && !is_one && (gap > thr.zero_thr);
    is_bit   = is_one || is_zero;
    bit_mask = {{(WordW-1){1'b0}}, 1'b1} << (LAST_BIT - cnt_r);
    word_nxt = word_r;
    cnt_nxt  = cnt_r;
    if (is_start) begin
      word_nxt = '0;
      cnt_nxt  = '0;
    end else if (is_bit) begin
      word_nxt = is_one ? (word_r | bit_mask) : (word_r & ~bit_mask);
      cnt_nxt  = cnt_r + 1'b1;
    end
    evt.done = is_bit && (cnt_r == LAST_BIT);
    evt.ok   = evt.done && (word_nxt[15:8] == ~word_nxt[7:0]);
    evt.word = word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
      cnt_r  <= '0;
    end else if (adv) begin
      word_r <= word_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

>>> hdl/ipdc_cmd_exec.sv
// ----------------------------------------------------------------------------
// ipdc_cmd_exec
// Command word match and motor control state (enable, direction, duty).
// ----------------------------------------------------------------------------
module ipdc_cmd_exec
  import ipdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  frame_evt_t  evt,
  input  cmd_cfg_t    cfg,
  output ctrl_state_t ctrl
);

  ctrl_state_t st_r, st_nxt;
  logic [LevelW:0] raised;

  always_comb begin
    raised = {1'b0, st_r.level} + {1'b0, LEVEL_STEP};
    st_nxt = st_r;
    if (evt.ok) begin
      if (evt.word == cfg.toggle_code) begin
        st_nxt.motor_on = ~st_r.motor_on;
      end else if (evt.word == cfg.reverse_code) begin
        st_nxt.direction = ~st_r.direction;
      end else if (evt.word == cfg.up_code) begin
        if (st_r.level < cfg.duty_ceiling) begin
          st_nxt.level = (raised > LEVEL_MAX) ? LEVEL_MAX[LevelW-1:0] : raised[LevelW-1:0];
        end
      end else if (evt.word == cfg.down_code) begin
        st_nxt.level = (st_r.level >= LEVEL_STEP) ? (st_r.level - LEVEL_STEP) : '0;
      end
    end
    ctrl = st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

endmodule

>>> hdl/ir_pulse_distance_command_decoder.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_command_decoder
// NEC-style IR receiver: decodes falling-edge intervals into 32-bit frames
// and drives motor enable, direction and duty level from command words.
// ----------------------------------------------------------------------------
// One input transfer per falling edge (interval in microseconds) gives exactly
// one result transfer. A new interval is taken every cycle unless in_stall is
// high; it passes the input register, combinational classify/shift/compare logic
// and the result register. The user must write configuration registers through
// cfg_wr_en/cfg_index/cfg_data only while no transfer is pending; the block does not enforce it.
module ir_pulse_distance_command_decoder
  import ipdc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         in_interval_us,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_frame_done,
  output logic                out_frame_ok,
  output logic [31:0]         out_frame_word,
  output logic [7:0]          out_duty_level,
  output logic                out_motor_on,
  output logic                out_direction,
  input  logic                cfg_wr_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  thr_cfg_t    thr_r;
  cmd_cfg_t    cmd_r;
  logic        in_vld_r;
  logic [GapW-1:0] gap_r;
  logic        adv;
  frame_evt_t  evt;
  ctrl_state_t ctrl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.start_thr    <= START_THR_RST;
      thr_r.one_thr      <= ONE_THR_RST;
      thr_r.zero_thr     <= ZERO_THR_RST;
      cmd_r.toggle_code  <= TOGGLE_RST;
      cmd_r.reverse_code <= REVERSE_RST;
      cmd_r.up_code      <= UP_RST;
      cmd_r.down_code    <= DOWN_RST;
      cmd_r.duty_ceiling <= CEILING_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_THR: thr_r.start_thr    <= cfg_data[GapW-1:0];
        REG_ONE_THR:   thr_r.one_thr      <= cfg_data[GapW-1:0];
        REG_ZERO_THR:  thr_r.zero_thr     <= cfg_data[GapW-1:0];
        REG_TOGGLE:    cmd_r.toggle_code  <= cfg_data[WordW-1:0];
        REG_REVERSE:   cmd_r.reverse_code <= cfg_data[WordW-1:0];
        REG_UP:        cmd_r.up_code      <= cfg_data[WordW-1:0];
        REG_DOWN:      cmd_r.down_code    <= cfg_data[WordW-1:0];
        REG_CEILING:   cmd_r.duty_ceiling <= cfg_data[LevelW-1:0];
        default: ;
      endcase
    end
  end

  // input register advances when the result register is free or draining
  assign adv      = in_vld_r && (!out_valid || !out_stall);
  assign in_stall = in_vld_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      gap_r <= in_interval_us;
    end
  end

  ipdc_frame_rx u_frame_rx (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .gap   (gap_r),
    .thr   (thr_r),
    .evt   (evt)
  );

  ipdc_cmd_exec u_cmd_exec (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .evt   (evt),
    .cfg   (cmd_r),
    .ctrl  (ctrl)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_frame_done <= evt.done;
      out_frame_ok   <= evt.ok;
      out_frame_word <= evt.word;
      out_duty_level <= ctrl.level;
      out_motor_on   <= ctrl.motor_on;
      out_direction  <= ctrl.direction;
    end
  end

endmodule

>>> tb/sv/ir_pulse_distance_command_decoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ir_pulse_distance_command_decoder_test
// Drives falling-edge intervals into the IR command decoder and checks every
// result against a cycle-free decoder kept in the bench: frame assembly,
// inverse byte check, command matching and duty level limits. The run steps
// through several register settings, including threshold and ceiling
// extremes, with random sender gaps, receiver stalls and a long hold-off.
// ----------------------------------------------------------------------------
module ir_pulse_distance_command_decoder_test;
  import ipdc_pkg::*;

  typedef struct {
    bit        done;
    bit        ok;
    bit [31:0] word;
    bit [7:0]  level;
    bit        motor;
    bit        dir;
  } decode_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [15:0]     in_interval_us = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic            out_frame_done;
  logic            out_frame_ok;
  logic [31:0]     out_frame_word;
  logic [7:0]      out_duty_level;
  logic            out_motor_on;
  logic            out_direction;
  logic            cfg_wr_en = 1'b0;
  cfg_reg_t        cfg_index = REG_START_THR;
  logic [31:0]     cfg_data = '0;

  // decoder settings as last written
  logic [15:0] start_thr = START_THR_RST;
  logic [15:0] one_thr = ONE_THR_RST;
  logic [15:0] zero_thr = ZERO_THR_RST;
  logic [31:0] cmd_toggle = TOGGLE_RST;
  logic [31:0] cmd_reverse = REVERSE_RST;
  logic [31:0] cmd_up = UP_RST;
  logic [31:0] cmd_down = DOWN_RST;
  logic [7:0]  duty_ceiling = CEILING_RST;

  // decoder state
  logic [31:0] shift_word = '0;
  int unsigned bit_count = 0;
  logic [7:0]  duty = '0;
  logic        motor = 1'b0;
  logic        dir = 1'b0;

  logic [15:0] gap_queue[$];
  decode_t     expected_results[$];
  int          items_queued = 0;
  int          items_accepted = 0;
  int          results_seen = 0;
  int          frames_done = 0;
  int          frames_ok = 0;
  int          peak_level = 0;
  int          settings_used = 0;
  int          fail_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  logic        in_took = 1'b0;

  ir_pulse_distance_command_decoder dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_interval_us(in_interval_us),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_frame_done(out_frame_done),
    .out_frame_ok  (out_frame_ok),
    .out_frame_word(out_frame_word),
    .out_duty_level(out_duty_level),
    .out_motor_on  (out_motor_on),
    .out_direction (out_direction),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic decode_t decode_edge(input logic [15:0] gap);
    decode_t     r;
    int unsigned pos;
    logic [8:0]  raised;
    r = '{default: 0};
    pos = 31 - (bit_count % 32);
    if (gap > start_thr) begin
      shift_word = '0;
      bit_count = 0;
    end else if (gap > one_thr) begin
      shift_word[pos] = 1'b1;
      bit_count++;
    end else if (gap > zero_thr) begin
      shift_word[pos] = 1'b0;
      bit_count++;
    end
    if (bit_count >= 32) begin
      r.done = 1'b1;
      if (shift_word[15:8] == ~shift_word[7:0]) begin
        r.ok = 1'b1;
        if (shift_word == cmd_toggle) begin
          motor = ~motor;
        end else if (shift_word == cmd_reverse) begin
          dir = ~dir;
        end else if (shift_word == cmd_up) begin
          if (duty < duty_ceiling) begin
            raised = {1'b0, duty} + LEVEL_STEP;
            duty = (raised > LEVEL_MAX) ? LEVEL_MAX[7:0] : raised[7:0];
          end
        end else if (shift_word == cmd_down) begin
          duty = (duty >= LEVEL_STEP) ? duty - LEVEL_STEP : 8'd0;
        end
      end
      bit_count = 0;
    end
    r.word = shift_word;
    r.level = duty;
    r.motor = motor;
    r.dir = dir;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // driver: new interval at the falling edge once the last one transferred
  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (rst_n && gap_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_interval_us <= gap_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with a counted hold-off on request
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor: check result transfers, predict on input transfers
  always @(posedge clk) begin
    decode_t want;
    in_took <= in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result transfer with no expected result pending");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("frame_done", want.done, out_frame_done);
          check_field("frame_ok", want.ok, out_frame_ok);
          check_field("frame_word", want.word, out_frame_word);
          check_field("duty_level", want.level, out_duty_level);
          check_field("motor_on", want.motor, out_motor_on);
          check_field("direction", want.dir, out_direction);
        end
      end
      if (in_valid && !in_stall) begin
        want = decode_edge(in_interval_us);
        expected_results.push_back(want);
        items_accepted++;
        if (want.done) frames_done++;
        if (want.ok) frames_ok++;
        if (want.level > peak_level) peak_level = want.level;
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (items_accepted != items_queued || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_START_THR: start_thr = value[15:0];
      REG_ONE_THR:   one_thr = value[15:0];
      REG_ZERO_THR:  zero_thr = value[15:0];
      REG_TOGGLE:    cmd_toggle = value;
      REG_REVERSE:   cmd_reverse = value;
      REG_UP:        cmd_up = value;
      REG_DOWN:      cmd_down = value;
      REG_CEILING:   duty_ceiling = value[7:0];
      default: ;
    endcase
  endtask

  // upper bits of the narrow registers carry junk
  task automatic load_settings(logic [15:0] s, logic [15:0] o, logic [15:0] z,
                               logic [31:0] tg, logic [31:0] rv, logic [31:0] up,
                               logic [31:0] dn, logic [7:0] ceil);
    write_reg(REG_START_THR, {16'($urandom), s});
    write_reg(REG_ONE_THR, {16'($urandom), o});
    write_reg(REG_ZERO_THR, {16'($urandom), z});
    write_reg(REG_TOGGLE, tg);
    write_reg(REG_REVERSE, rv);
    write_reg(REG_UP, up);
    write_reg(REG_DOWN, dn);
    write_reg(REG_CEILING, {24'($urandom), ceil});
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  function automatic void push_gap(logic [15:0] g);
    gap_queue.push_back(g);
    items_queued++;
  endfunction

  // random value in (lo, hi], anything when that range is empty
  function automatic logic [15:0] gap_in(int lo, int hi);
    if (lo < hi) return 16'($urandom_range(hi, lo + 1));
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] nec_word();
    logic [7:0] c;
    c = 8'($urandom);
    return {16'($urandom), ~c, c};
  endfunction

  function automatic logic [31:0] pick_command(int up_pct, int down_pct);
    int r;
    r = $urandom_range(99);
    if (r < up_pct) return cmd_up;
    if (r < up_pct + down_pct) return cmd_down;
    if (r < up_pct + down_pct + 10) return cmd_toggle;
    if (r < up_pct + down_pct + 20) return cmd_reverse;
    if (r < up_pct + down_pct + 28) return nec_word();
    return $urandom;
  endfunction

  // start gap, then bits MSB first; may be cut short or salted with short gaps
  function automatic void push_frame(logic [31:0] word, int noise_pct, int trunc_pct);
    int bits;
    bits = ($urandom_range(99) < trunc_pct) ? $urandom_range(31, 1) : 32;
    push_gap(gap_in(start_thr, 65535));
    for (int i = 31; i > 31 - bits; i--) begin
      if ($urandom_range(99) < noise_pct) push_gap(gap_in(-1, zero_thr));
      push_gap(word[i] ? gap_in(one_thr, start_thr) : gap_in(zero_thr, one_thr));
    end
  endfunction

  function automatic void push_frames(int n, int up_pct, int down_pct, int noise_pct,
                                      int trunc_pct);
    repeat (n) push_frame(pick_command(up_pct, down_pct), noise_pct, trunc_pct);
  endfunction

  function automatic void push_noise(int n, int zero_pct);
    repeat (n) push_gap(($urandom_range(99) < zero_pct) ? 16'd0 : 16'($urandom));
  endfunction

  initial begin
    logic [31:0] same_code;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // threshold boundaries under reset settings
    @(posedge clk);
    push_gap(16'd0);
    push_gap(16'hFFFF);
    push_gap(16'd8000);
    push_gap(16'd8001);
    push_gap(16'd1700);
    push_gap(16'd1701);
    push_gap(16'd1000);
    push_gap(16'd1001);
    push_gap(16'h5555);
    push_gap(16'hAAAA);
    push_gap(16'd999);
    wait_drained();

    load_settings(START_THR_RST, ONE_THR_RST, ZERO_THR_RST, TOGGLE_RST, REVERSE_RST,
                  UP_RST, DOWN_RST, CEILING_RST);
    @(posedge clk);
    push_frames(2, 70, 5, 10, 0);
    push_noise(20, 10);
    wait_drained();

    // sender gaps; raise to the top ceiling
    load_settings(16'd9000, 16'd1600, 16'd560, nec_word(), nec_word(), nec_word(),
                  nec_word(), 8'd255);
    @(posedge clk);
    send_idle_pct = 55;
    push_frames(26, 100, 0, 0, 0);
    push_frames(2, 0, 50, 5, 10);
    wait_drained();

    // receiver stalls; shared command words, ceiling at zero
    same_code = nec_word();
    load_settings(START_THR_RST, ONE_THR_RST, ZERO_THR_RST, same_code, same_code,
                  nec_word(), same_code, 8'd0);
    @(posedge clk);
    send_idle_pct = 0;
    stall_pct = 55;
    push_frame(same_code, 0, 0);
    push_frame(cmd_up, 0, 0);
    push_frames(1, 30, 30, 10, 20);
    wait_drained();

    load_settings(16'd0, 16'd0, 16'd0, 32'h0, 32'hFFFF_FFFF, nec_word(), nec_word(), 8'd245);
    @(posedge clk);
    push_noise(15, 25);
    wait_drained();
    load_settings(16'hFFFF, 16'hFFFF, 16'd0, TOGGLE_RST, REVERSE_RST, UP_RST, DOWN_RST,
                  8'd100);
    @(posedge clk);
    push_noise(15, 25);
    wait_drained();
    load_settings(16'hFFFF, 16'd0, 16'hFFFF, TOGGLE_RST, REVERSE_RST, UP_RST, DOWN_RST,
                  8'd100);
    @(posedge clk);
    push_noise(15, 25);
    wait_drained();

    // both sides idle at random; mostly down commands to lower the level
    load_settings(16'd7000, 16'd1500, 16'd600, TOGGLE_RST, REVERSE_RST, UP_RST, DOWN_RST,
                  8'd245);
    @(posedge clk);
    send_idle_pct = 24;
    stall_pct = 24;
    push_frames(2, 10, 60, 15, 15);
    wait_drained();
    @(posedge clk);
    push_frames(1, 10, 60, 15, 15);
    wait_drained();

    // receiver holds off while the sender keeps offering
    @(posedge clk);
    send_idle_pct = 0;
    stall_pct = 0;
    push_frames(1, 30, 30, 10, 0);
    hold_req++;
    wait_drained();

    load_settings(START_THR_RST, ONE_THR_RST, ZERO_THR_RST, TOGGLE_RST, REVERSE_RST,
                  UP_RST, DOWN_RST, 8'd120);
    @(posedge clk);
    push_frames(1, 40, 20, 10, 10);
    wait_drained();
    repeat (10) @(posedge clk);

    $display("Ran %0d intervals and %0d results over %0d register settings.",
             items_accepted, results_seen, settings_used);
    $display("Frames completed: %0d, passing the byte check: %0d; peak duty level %0d.",
             frames_done, frames_ok, peak_level);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
